@@ rtl/core/bau_pkg.sv @@
package bau_pkg;

   localparam int PRESSURE_FRAC_BITS = 8;
   localparam int PRESSURE_W = 25;
   localparam int ALT_W = 25;
   localparam int CFG_W = 17;

   localparam logic [1:0] CMD_ALT   = 2'd0;
   localparam logic [1:0] CMD_RECAL = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;

   localparam logic [0:0] REG_TEMP   = 1'd0;
   localparam logic [0:0] REG_WEIGHT = 1'd1;

   localparam logic [CFG_W-1:0] TEMP_RESET   = 17'd76006;
   localparam logic [CFG_W-1:0] WEIGHT_RESET = 17'd655;
   localparam logic [CFG_W-1:0] WEIGHT_ONE   = 17'd65536;

   localparam logic [PRESSURE_W-1:0] GROUND_RESET =
      PRESSURE_W'(64'd93690 << PRESSURE_FRAC_BITS);
   localparam logic [PRESSURE_W-1:0] GROUND_SEA_LEVEL =
      PRESSURE_W'(64'd101325 << PRESSURE_FRAC_BITS);

   localparam logic [31:0] EXPONENT_Q20 = 32'd199509;
   localparam logic [31:0] ALT_SCALE = 32'd2000;
   // ceil(2^34 / 13): x / 13 == (x * DIV_MAGIC) >> 34 for any 32-bit x
   localparam logic [31:0] DIV_MAGIC = 32'h4EC4EC4F;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [PRESSURE_W-1:0] pressure;
   } job_type;

   typedef struct packed {
      logic [CFG_W-1:0] temp;
      logic [CFG_W-1:0] weight;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic taken;
   } ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } sts_type;

   typedef struct packed {
      logic [ALT_W-1:0]      altitude;
      logic                  error;
      logic [PRESSURE_W-1:0] ground;
   } result_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-(k+1)) in Q.30, floor at each root
   function automatic logic [31:0] root_const(input int k);
      logic [63:0] r;
      r = isqrt64(64'd2 << 60);
      for (int j = 0; j < 24; j++) begin
         if (j < k) r = isqrt64(r << 30);
      end
      return r[31:0];
   endfunction

endpackage

@@ rtl/core/bau_mul.sv @@
module bau_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/core/bau_core.sv @@
module bau_core (
   input  logic                clock,
   input  logic                reset,
   input  bau_pkg::ctl_type    ctl,
   input  bau_pkg::job_type    job,
   input  bau_pkg::cfg_type    cfg,
   output bau_pkg::sts_type    sts,
   output bau_pkg::result_type res
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_LOG_INIT = 5'd1;
   localparam logic [4:0] S_LOG_MUL  = 5'd2;
   localparam logic [4:0] S_LOG_ACC  = 5'd3;
   localparam logic [4:0] S_Y_MUL    = 5'd4;
   localparam logic [4:0] S_Y_ACC    = 5'd5;
   localparam logic [4:0] S_EXP_MUL  = 5'd6;
   localparam logic [4:0] S_EXP_ACC  = 5'd7;
   localparam logic [4:0] S_SHIFT    = 5'd8;
   localparam logic [4:0] S_K_MUL    = 5'd9;
   localparam logic [4:0] S_K_ACC    = 5'd10;
   localparam logic [4:0] S_LO_MUL   = 5'd11;
   localparam logic [4:0] S_LO_ACC   = 5'd12;
   localparam logic [4:0] S_HI_MUL   = 5'd13;
   localparam logic [4:0] S_HI_ACC   = 5'd14;
   localparam logic [4:0] S_DIV_MUL  = 5'd15;
   localparam logic [4:0] S_ROUND    = 5'd16;
   localparam logic [4:0] S_EMA_A    = 5'd17;
   localparam logic [4:0] S_EMA_B    = 5'd18;
   localparam logic [4:0] S_EMA_C    = 5'd19;
   localparam logic [4:0] S_DONE     = 5'd20;
   localparam logic [4:0] S_DIV_ACC  = 5'd21;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [24:0] p_ff, p_in;
   logic [24:0] g_ff, g_in;
   logic        phase_ff, phase_in;
   logic [30:0] m_ff, m_in;
   logic [28:0] r_ff, r_in;
   logic [28:0] l1_ff, l1_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [23:0] f_ff, f_in;
   logic [3:0]  ip_ff, ip_in;
   logic [31:0] acc_ff, acc_in;
   logic [36:0] mag_ff, mag_in;
   logic [27:0] k_ff, k_in;
   logic [63:0] num_ff, num_in;
   logic [3:0]  rem_ff, rem_in;
   logic [24:0] alt_ff, alt_in;
   logic        err_ff, err_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [31:0] root_tab [24];

   logic [24:0] log_x;
   logic [4:0]  lod_n;
   logic [30:0] log_m0;
   logic [31:0] sq;
   logic [29:0] diff;
   logic [28:0] dmag;
   logic [47:0] ysum;
   logic [27:0] yv;
   logic [62:0] esum;
   logic [2:0]  lsh;
   logic [3:0]  rsh;
   logic [36:0] pw;
   logic [36:0] one_q30;
   logic [19:0] dx;
   logic [15:0] dq;
   logic [19:0] d13;
   logic [19:0] drem;
   logic [64:0] rsum;
   logic [34:0] qv;
   logic [16:0] wa;
   logic [16:0] wb;
   logic [63:0] emasum;

   bau_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   for (genvar g = 0; g < 24; g++) begin : g_root
      localparam logic [31:0] ROOT = bau_pkg::root_const(23 - g);
      assign root_tab[g] = ROOT;
   end

   assign log_x = phase_ff ? g_ff : p_ff;

   always_comb begin
      lod_n = 5'd0;
      for (int i = 0; i < 25; i++) begin
         if (log_x[i]) lod_n = 5'(i);
      end
   end

   assign log_m0  = {6'd0, log_x} << (5'd30 - lod_n);
   assign sq      = prod[61:30];
   assign diff    = {1'b0, l1_ff} - {1'b0, r_ff};
   assign dmag    = diff[29] ? 29'(-diff) : diff[28:0];
   assign ysum    = prod[47:0] + (48'd1 << 19);
   assign yv      = neg_ff ? -{1'b0, ysum[46:20]} : {1'b0, ysum[46:20]};
   assign esum    = prod[62:0] + (63'd1 << 29);
   assign lsh     = (ip_ff > 4'd5) ? 3'd5 : ip_ff[2:0];
   assign rsh     = 4'(-ip_ff);
   assign pw      = ip_ff[3] ? ({5'd0, acc_ff} >> rsh) : ({5'd0, acc_ff} << lsh);
   assign one_q30 = 37'd1 << 30;
   assign dx      = {rem_ff, num_ff[63:48]};
   assign dq      = prod[49:34];
   assign d13     = ({4'd0, dq} << 3) + ({4'd0, dq} << 2) + {4'd0, dq};
   assign drem    = dx - d13;
   assign rsum    = {1'b0, num_ff} + (65'd1 << 29);
   assign qv      = rsum[64:30];
   assign wa      = (cfg.weight > bau_pkg::WEIGHT_ONE) ? bau_pkg::WEIGHT_ONE : cfg.weight;
   assign wb      = bau_pkg::WEIGHT_ONE - wa;
   assign emasum  = num_ff + prod + 64'd32768;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      p_in     = p_ff;
      g_in     = g_ff;
      phase_in = phase_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      l1_in    = l1_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      f_in     = f_ff;
      ip_in    = ip_ff;
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      k_in     = k_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      alt_in   = alt_ff;
      err_in   = err_ff;
      mul_a    = 32'd0;
      mul_b    = 32'd0;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               cmd_in = job.cmd;
               p_in   = job.pressure;
               alt_in = 25'd0;
               err_in = 1'b0;
               case (job.cmd)
                  bau_pkg::CMD_ALT: begin
                     if (job.pressure == 25'd0 || g_ff == 25'd0) begin
                        err_in   = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        phase_in = 1'b0;
                        state_in = S_LOG_INIT;
                     end
                  end
                  bau_pkg::CMD_RECAL: begin
                     if (job.pressure == 25'd0) begin
                        state_in = S_DONE;
                     end else if (g_ff == bau_pkg::GROUND_SEA_LEVEL) begin
                        g_in     = job.pressure;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_EMA_A;
                     end
                  end
                  bau_pkg::CMD_SET: begin
                     if (job.pressure != 25'd0) g_in = job.pressure;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LOG_INIT: begin
            m_in     = log_m0;
            r_in     = {lod_n, 24'd0};
            cnt_in   = 6'd23;
            state_in = S_LOG_MUL;
         end
         S_LOG_MUL: begin
            mul_a    = {1'b0, m_ff};
            mul_b    = {1'b0, m_ff};
            state_in = S_LOG_ACC;
         end
         S_LOG_ACC: begin
            if (sq[31]) begin
               m_in = sq[31:1];
               r_in = r_ff | (29'd1 << cnt_ff[4:0]);
            end else begin
               m_in = sq[30:0];
            end
            if (cnt_ff == 6'd0) begin
               if (!phase_ff) begin
                  l1_in    = r_in;
                  phase_in = 1'b1;
                  state_in = S_LOG_INIT;
               end else begin
                  state_in = S_Y_MUL;
               end
            end else begin
               cnt_in   = cnt_ff - 6'd1;
               state_in = S_LOG_MUL;
            end
         end
         S_Y_MUL: begin
            mul_a    = {3'd0, dmag};
            mul_b    = bau_pkg::EXPONENT_Q20;
            neg_in   = diff[29];
            state_in = S_Y_ACC;
         end
         S_Y_ACC: begin
            f_in     = yv[23:0];
            ip_in    = yv[27:24];
            acc_in   = 32'd1 << 30;
            cnt_in   = 6'd23;
            state_in = S_EXP_MUL;
         end
         S_EXP_MUL: begin
            if (f_ff[cnt_ff[4:0]]) begin
               mul_a    = acc_ff;
               mul_b    = root_tab[cnt_ff[4:0]];
               state_in = S_EXP_ACC;
            end else if (cnt_ff == 6'd0) begin
               state_in = S_SHIFT;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_EXP_ACC: begin
            acc_in = esum[61:30];
            if (cnt_ff == 6'd0) begin
               state_in = S_SHIFT;
            end else begin
               cnt_in   = cnt_ff - 6'd1;
               state_in = S_EXP_MUL;
            end
         end
         S_SHIFT: begin
            if (pw <= one_q30) begin
               mag_in = one_q30 - pw;
               neg_in = 1'b0;
            end else begin
               mag_in = pw - one_q30;
               neg_in = 1'b1;
            end
            state_in = S_K_MUL;
         end
         S_K_MUL: begin
            mul_a    = {15'd0, cfg.temp};
            mul_b    = bau_pkg::ALT_SCALE;
            state_in = S_K_ACC;
         end
         S_K_ACC: begin
            k_in     = prod[27:0];
            state_in = S_LO_MUL;
         end
         S_LO_MUL: begin
            mul_a    = mag_ff[31:0];
            mul_b    = {4'd0, k_ff};
            state_in = S_LO_ACC;
         end
         S_LO_ACC: begin
            num_in   = prod;
            state_in = S_HI_MUL;
         end
         S_HI_MUL: begin
            mul_a    = {27'd0, mag_ff[36:32]};
            mul_b    = {4'd0, k_ff};
            state_in = S_HI_ACC;
         end
         S_HI_ACC: begin
            num_in   = num_ff + {prod[31:0], 32'd0};
            rem_in   = 4'd0;
            cnt_in   = 6'd3;
            state_in = S_DIV_MUL;
         end
         S_DIV_MUL: begin
            mul_a    = {12'd0, dx};
            mul_b    = bau_pkg::DIV_MAGIC;
            state_in = S_DIV_ACC;
         end
         S_DIV_ACC: begin
            rem_in = drem[3:0];
            num_in = {num_ff[47:0], dq};
            if (cnt_ff == 6'd0) begin
               state_in = S_ROUND;
            end else begin
               cnt_in   = cnt_ff - 6'd1;
               state_in = S_DIV_MUL;
            end
         end
         S_ROUND: begin
            if (neg_ff) begin
               alt_in = (qv > 35'd16777216) ? 25'h1000000 : 25'(-qv);
            end else begin
               alt_in = (qv > 35'd16777215) ? 25'hFFFFFF : qv[24:0];
            end
            state_in = S_DONE;
         end
         S_EMA_A: begin
            mul_a    = {15'd0, wa};
            mul_b    = {7'd0, p_ff};
            state_in = S_EMA_B;
         end
         S_EMA_B: begin
            num_in   = prod;
            mul_a    = {15'd0, wb};
            mul_b    = {7'd0, g_ff};
            state_in = S_EMA_C;
         end
         S_EMA_C: begin
            g_in     = emasum[40:16];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctl.taken) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         g_ff     <= bau_pkg::GROUND_RESET;
      end else begin
         state_ff <= state_in;
         g_ff     <= g_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      p_ff     <= p_in;
      phase_ff <= phase_in;
      m_ff     <= m_in;
      r_ff     <= r_in;
      l1_ff    <= l1_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      f_ff     <= f_in;
      ip_ff    <= ip_in;
      acc_ff   <= acc_in;
      mag_ff   <= mag_in;
      k_ff     <= k_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      alt_ff   <= alt_in;
      err_ff   <= err_in;
   end

   assign sts.idle     = (state_ff == S_IDLE);
   assign sts.done     = (state_ff == S_DONE);
   assign res.altitude = alt_ff;
   assign res.error    = err_ff;
   assign res.ground   = g_ff;

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !ctl.taken) |=> (state_ff == S_DONE))
      else $error("result dropped before it was taken");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (state_ff == S_IDLE))
      else $error("start outside idle");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && err_ff) |-> (alt_ff == 25'd0 && cmd_ff == bau_pkg::CMD_ALT))
      else $error("error with nonzero altitude");

   a_other_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && cmd_ff != bau_pkg::CMD_ALT) |-> (alt_ff == 25'd0 && !err_ff))
      else $error("altitude or error set for a non-altitude command");

endmodule

@@ rtl/core/barometric_altitude_unit.sv @@
// Barometric altitude unit.
// req channel: tuser carries the command (0 altitude, 1 recalibrate, 2 set
// ground pressure), tdata the pressure in 1/256 Pa. rsp channel: one beat per
// request; tdata carries the altitude in 1/256 m (signed, saturated) and the
// ground pressure after the request, tuser the error flag.
// csr channel: index 0 writes ground temperature (1/256 K), index 1 the
// moving average weight (Q1.16); always ready, write only while idle.
// One request is processed at a time; req_tready is low while it runs.
// An altitude request runs two 24-step log2 loops and a 24-step exp2 loop
// on the shared 32x32 multiplier, then a divide by 13 in four 16-bit
// reciprocal-multiply steps.
// The rsp beat sits in an output register; the core may start the next
// request while it waits, and holds its own result if the register is full.
// Reset (synchronous) restores the ground pressure to 93690 Pa, the
// registers to their defaults and drops any pending beat.
module barometric_altitude_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pressure[24:0], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // altitude[24:0], ground_pressure_now[49:25], zero pad
   output logic        rsp_tuser,   // error[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_data
);

   logic [16:0] temp_ff, temp_in;
   logic [16:0] weight_ff, weight_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bau_pkg::result_type rsp_ff, rsp_in;

   bau_pkg::ctl_type    ctl;
   bau_pkg::sts_type    sts;
   bau_pkg::job_type    job;
   bau_pkg::cfg_type    cfg;
   bau_pkg::result_type res;
   logic                take;

   assign csr_ready = 1'b1;
   assign req_tready = sts.idle;

   assign job.cmd      = req_tuser;
   assign job.pressure = req_tdata[24:0];
   assign cfg.temp     = temp_ff;
   assign cfg.weight   = weight_ff;

   assign take      = sts.done && (!rsp_valid_ff || rsp_tready);
   assign ctl.start = req_tvalid && req_tready;
   assign ctl.taken = take;

   bau_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .job   (job),
      .cfg   (cfg),
      .sts   (sts),
      .res   (res)
   );

   always_comb begin
      temp_in   = temp_ff;
      weight_in = weight_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bau_pkg::REG_TEMP:   temp_in = csr_data;
            bau_pkg::REG_WEIGHT: weight_in = csr_data;
            default: begin
               temp_in = temp_ff;
            end
         endcase
      end
      rsp_in = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff      <= bau_pkg::TEMP_RESET;
         weight_ff    <= bau_pkg::WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         temp_ff      <= temp_in;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.ground, rsp_ff.altitude};
   assign rsp_tuser  = rsp_ff.error;

endmodule
